// ===== rtl/plcfs_pkg.sv =====
package plcfs_pkg;

    // Command codes carried on i_command.
    localparam logic CMD_ARRIVE   = 1'b0;
    localparam logic CMD_COMPLETE = 1'b1;

    // Shift control that every stack cell receives in the same cycle.
    typedef struct packed {
        logic push;   // take the entry of the neighbor above (toward the top)
        logic pop;    // take the entry of the neighbor below (toward the bottom)
    } t_shift_ctrl;

endpackage

// ===== rtl/plcfs_cell.sv =====
module plcfs_cell #(
    parameter int ID_BITS   = 16,
    parameter int TIME_BITS = 48
) (
    input  logic                     i_clk,
    input  plcfs_pkg::t_shift_ctrl   i_ctrl,
    input  logic [ID_BITS-1:0]       i_up_id,
    input  logic [TIME_BITS-1:0]     i_up_rem,
    input  logic [ID_BITS-1:0]       i_dn_id,
    input  logic [TIME_BITS-1:0]     i_dn_rem,
    output logic [ID_BITS-1:0]       o_id,
    output logic [TIME_BITS-1:0]     o_rem
);

    logic [ID_BITS-1:0]   r_id;
    logic [TIME_BITS-1:0] r_rem;
    logic [ID_BITS-1:0]   n_id;
    logic [TIME_BITS-1:0] n_rem;

    // A push moves every entry one place away from the top, a pop one place
    // toward it. Otherwise the cell keeps its entry.
    always_comb begin
        n_id  = r_id;
        n_rem = r_rem;
        if (i_ctrl.push) begin
            n_id  = i_up_id;
            n_rem = i_up_rem;
        end else if (i_ctrl.pop) begin
            n_id  = i_dn_id;
            n_rem = i_dn_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id  <= n_id;
        r_rem <= n_rem;
    end

    assign o_id  = r_id;
    assign o_rem = r_rem;

endmodule

// ===== rtl/preemptive_lcfs_scheduler.sv =====
// Channel   Direction  Handshake                     Payload
// command   in         start & !busy at rising edge  i_command, i_job_id, i_job_time,
//                                                    i_current_time
// result    out        o_valid, one cycle, no stall  o_completed_valid, o_done_job,
//                                                    o_cancel_previous, o_schedule_valid,
//                                                    o_next_completion_time, o_overflow
//
// Each command is handled in two steps: the transfer edge registers the command and the
// elapsed time since the last mark, the next cycle updates the top of the stack
// and registers the result, which is shown on o_valid for the cycle after that.
// The two steps are set by the elapsed-time subtract and the saturating charge
// of the top entry, which sit in separate cycles. busy is high for one cycle
// after each transfer, so a new command can be taken only once busy has dropped again.
// Reset (synchronous, active low) empties the stack and clears the time mark.
// The receiver cannot stall, so there is no back pressure on the result side.
module preemptive_lcfs_scheduler #(
    parameter int STACK_DEPTH = 64,
    parameter int ID_BITS     = 16,
    parameter int TIME_BITS   = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_command,
    input  logic [ID_BITS-1:0]    i_job_id,
    input  logic [TIME_BITS-1:0]  i_job_time,
    input  logic [TIME_BITS-1:0]  i_current_time,
    output logic                  o_valid,
    output logic                  o_completed_valid,
    output logic [ID_BITS-1:0]    o_done_job,
    output logic                  o_cancel_previous,
    output logic                  o_schedule_valid,
    output logic [TIME_BITS-1:0]  o_next_completion_time,
    output logic                  o_overflow
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                r_state;
    logic [CNT_W-1:0]      r_count;
    logic [TIME_BITS-1:0]  r_last_mark;

    // Command held for the execute cycle.
    logic                  r_cmd;
    logic [ID_BITS-1:0]    r_id;
    logic [TIME_BITS-1:0]  r_jt;
    logic [TIME_BITS-1:0]  r_now;
    logic [TIME_BITS-1:0]  r_elapsed;

    // The stack is a row of cells; cell 0 is the top of the stack.
    logic [ID_BITS-1:0]    w_id  [STACK_DEPTH];
    logic [TIME_BITS-1:0]  w_rem [STACK_DEPTH];

    plcfs_pkg::t_shift_ctrl w_ctrl;
    logic                  w_exec;
    logic                  w_full;
    logic                  w_empty;
    logic [TIME_BITS-1:0]  w_elapsed;
    logic [TIME_BITS-1:0]  w_charged;
    logic [TIME_BITS-1:0]  w_sum_b;
    logic [TIME_BITS-1:0]  w_sum;

    assign busy    = (r_state == S_EXEC);
    assign w_exec  = (r_state == S_EXEC);
    assign w_full  = (r_count == CNT_FULL);
    assign w_empty = (r_count == '0);

    // Time since the last mark, taken as zero when time runs backwards. It is
    // computed from the ports and the mark at the transfer edge; the mark only
    // moves at the end of the execute cycle, while busy holds off new commands.
    assign w_elapsed = (i_current_time >= r_last_mark) ? (i_current_time - r_last_mark)
                                                      : '0;

    // The preempted top job is charged the elapsed time, saturating at zero,
    // on its way down into cell 1.
    assign w_charged = (w_rem[0] > r_elapsed) ? (w_rem[0] - r_elapsed) : '0;

    // An arrival schedules the new job; a completion schedules the job that
    // becomes the top, which sits in cell 1 before the pop. The sum wraps.
    assign w_sum_b = (r_cmd == plcfs_pkg::CMD_ARRIVE) ? r_jt : w_rem[1];
    assign w_sum   = r_now + w_sum_b;

    always_comb begin
        w_ctrl.push = w_exec && (r_cmd == plcfs_pkg::CMD_ARRIVE) && !w_full;
        w_ctrl.pop  = w_exec && (r_cmd == plcfs_pkg::CMD_COMPLETE) && !w_empty;
    end

    for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
        logic [ID_BITS-1:0]   w_up_id;
        logic [TIME_BITS-1:0] w_up_rem;
        logic [ID_BITS-1:0]   w_dn_id;
        logic [TIME_BITS-1:0] w_dn_rem;

        if (k == 0) begin : g_top
            assign w_up_id  = r_id;
            assign w_up_rem = r_jt;
        end else if (k == 1) begin : g_second
            assign w_up_id  = w_id[0];
            assign w_up_rem = w_charged;
        end else begin : g_mid
            assign w_up_id  = w_id[k-1];
            assign w_up_rem = w_rem[k-1];
        end

        if (k == STACK_DEPTH - 1) begin : g_bottom
            assign w_dn_id  = w_id[k];
            assign w_dn_rem = w_rem[k];
        end else begin : g_inner
            assign w_dn_id  = w_id[k+1];
            assign w_dn_rem = w_rem[k+1];
        end

        plcfs_cell #(
            .ID_BITS   (ID_BITS),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl),
            .i_up_id  (w_up_id),
            .i_up_rem (w_up_rem),
            .i_dn_id  (w_dn_id),
            .i_dn_rem (w_dn_rem),
            .o_id     (w_id[k]),
            .o_rem    (w_rem[k])
        );
    end

    // Sequencer: IDLE takes a command, EXEC updates the stack and registers
    // the result, which is strobed in the following cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_last_mark <= '0;
            o_valid     <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    o_valid <= 1'b0;
                    if (start) begin
                        r_cmd     <= i_command;
                        r_id      <= i_job_id;
                        r_jt      <= i_job_time;
                        r_now     <= i_current_time;
                        r_elapsed <= w_elapsed;
                        r_state   <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    o_valid                <= 1'b1;
                    o_completed_valid      <= 1'b0;
                    o_done_job             <= '0;
                    o_cancel_previous      <= 1'b0;
                    o_schedule_valid       <= 1'b0;
                    o_next_completion_time <= '0;
                    o_overflow             <= 1'b0;
                    if (r_cmd == plcfs_pkg::CMD_ARRIVE) begin
                        if (w_full) begin
                            // Dropped arrival: nothing is charged and the mark stays.
                            o_overflow <= 1'b1;
                        end else begin
                            o_cancel_previous      <= !w_empty;
                            o_schedule_valid       <= 1'b1;
                            o_next_completion_time <= w_sum;
                            r_count                <= r_count + CNT_ONE;
                            r_last_mark            <= r_now;
                        end
                    end else if (!w_empty) begin
                        o_completed_valid <= 1'b1;
                        o_done_job        <= w_id[0];
                        r_count           <= r_count - CNT_ONE;
                        // Only a job left behind on the stack gets a new mark.
                        if (r_count != CNT_ONE) begin
                            o_schedule_valid       <= 1'b1;
                            o_next_completion_time <= w_sum;
                            r_last_mark            <= r_now;
                        end
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_valid_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_EXEC))
        else $error("result strobe without an execute cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("stack count beyond depth");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.push |=> (r_count == $past(r_count) + CNT_ONE))
        else $error("push did not grow the stack by one");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_completed_valid) |-> (r_count == $past(r_count) - CNT_ONE))
        else $error("completion did not shrink the stack by one");

    a_overflow_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |->
            (!o_schedule_valid && !o_cancel_previous && !o_completed_valid && w_full))
        else $error("overflow result with other fields set or stack not full");
`endif

endmodule
